>>> src/ght_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ght_pkg
// shared types and constants of the generational handle table
// ----------------------------------------------------------------------------
package ght_pkg;

  localparam int SLOTS_DEF = 64;
  localparam int OP_W      = 2;
  localparam int WORD_W    = 32;
  localparam int HANDLE_W  = 31;
  localparam int CTX_W     = 32;
  localparam int GEN_W     = 15;
  localparam int LOW_W     = 16;
  localparam int SLOT_W    = 6;
  localparam int STATUS_W  = 2;
  localparam int GROUP_MAX = 32;

  localparam logic [GEN_W-1:0] GEN_LIMIT = '1;
  localparam logic [GEN_W-1:0] GEN_FIRST = GEN_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_RSVD   = 2'd3
  } ght_op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_MISMATCH = 2'd2,
    ST_FULL     = 2'd3
  } ght_status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } ght_state_e;

  typedef struct packed {
    logic load;
    logic commit;
  } ght_cmd_t;

  typedef struct packed {
    logic out_free;
  } ght_sts_t;

endpackage
`default_nettype wire

>>> src/generational_handle_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// generational_handle_table
// slot table that allocates, frees and looks up generation-tagged handles
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  op_i, handle_i, context_req_i
//   out      output     out_valid_o/out_stall_i status_o, new_handle_o, slot_o,
//                                              context_out_o
//
// per word, the accept cycle issues the slot store read, and the commit
// cycle checks the handle, updates the table and loads the output register;
// the commit cycle works on the registered read of the slot store
// reset clears the used bits, the generation and the control state at once
// one finished word may wait in the output register while the next is taken;
// the commit cycle waits until that register is free
// ----------------------------------------------------------------------------
module generational_handle_table #(
  parameter int SLOTS = ght_pkg::SLOTS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire logic [ght_pkg::OP_W-1:0]      op_i,
  input  wire logic [ght_pkg::WORD_W-1:0]    handle_i,
  input  wire logic [ght_pkg::CTX_W-1:0]     context_req_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic [ght_pkg::STATUS_W-1:0]  status_o,
  output      logic [ght_pkg::HANDLE_W-1:0]  new_handle_o,
  output      logic [ght_pkg::SLOT_W-1:0]    slot_o,
  output      logic [ght_pkg::CTX_W-1:0]     context_out_o
);
  import ght_pkg::*;

  ght_cmd_t cmd;
  ght_sts_t sts;

  ght_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ght_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .op_i          (op_i),
    .handle_i      (handle_i),
    .context_req_i (context_req_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .new_handle_o  (new_handle_o),
    .slot_o        (slot_o),
    .context_out_o (context_out_o)
  );

endmodule
`default_nettype wire

>>> src/ght_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ght_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module ght_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> src/ght_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ght_ctrl
// sequencer: takes a word, then commits it once the output register is free
// ----------------------------------------------------------------------------
module ght_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_stall_o,
  input  wire ght_pkg::ght_sts_t sts_i,
  output      ght_pkg::ght_cmd_t cmd_o
);
  import ght_pkg::*;

  ght_state_e state_q;
  ght_state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    cmd_o      = '0;
    case (state_q)
      FSM_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
        if (in_valid_i) begin
          state_d = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        cmd_o.commit = sts_i.out_free;
        if (sts_i.out_free) begin
          state_d = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> src/ght_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ght_dp
// datapath: slot store, used bits, free-slot search, checks, output register
// ----------------------------------------------------------------------------
module ght_dp #(
  parameter int SLOTS = ght_pkg::SLOTS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ght_pkg::ght_cmd_t             cmd_i,
  output      ght_pkg::ght_sts_t             sts_o,
  input  wire logic [ght_pkg::OP_W-1:0]      op_i,
  input  wire logic [ght_pkg::WORD_W-1:0]    handle_i,
  input  wire logic [ght_pkg::CTX_W-1:0]     context_req_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic [ght_pkg::STATUS_W-1:0]  status_o,
  output      logic [ght_pkg::HANDLE_W-1:0]  new_handle_o,
  output      logic [ght_pkg::SLOT_W-1:0]    slot_o,
  output      logic [ght_pkg::CTX_W-1:0]     context_out_o
);
  import ght_pkg::*;

  localparam int IDX_W   = $clog2(SLOTS);
  localparam int GRP_W   = (SLOTS < GROUP_MAX) ? SLOTS : GROUP_MAX;
  localparam int NGRP    = (SLOTS + GRP_W - 1) / GRP_W;
  localparam int PAD_W   = NGRP * GRP_W;
  localparam int GIDX_W  = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int OFF_W   = $clog2(GRP_W);
  localparam int ENTRY_W = CTX_W + HANDLE_W;
  localparam logic [LOW_W:0] SLOTS_L = (LOW_W + 1)'(SLOTS);

  // item registers
  ght_op_e             op_q;
  logic [WORD_W-1:0]   handle_q;
  logic [CTX_W-1:0]    ctx_q;
  logic [GIDX_W-1:0]   grp_q;
  logic                grp_found_q;
  logic [GEN_W-1:0]    gen_q;
  logic [SLOTS-1:0]    used_q;

  // output register
  logic                out_valid_q;
  ght_status_e         status_q;
  logic [HANDLE_W-1:0] new_handle_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [CTX_W-1:0]    ctx_out_q;

  logic [PAD_W-1:0]    used_pad;
  logic [NGRP-1:0]     grp_free;
  logic [GIDX_W-1:0]   grp_d;
  logic [GRP_W-1:0]    grp_bits;
  logic [OFF_W-1:0]    off;
  logic [IDX_W-1:0]    alloc_idx;
  logic [GEN_W-1:0]    gen_inc;
  logic [GEN_W-1:0]    gen_next;
  logic [HANDLE_W-1:0] alloc_handle;

  logic [LOW_W-1:0]    low_in;
  logic [LOW_W-1:0]    low_q;
  logic [LOW_W-1:0]    dec_in;
  logic [LOW_W-1:0]    dec_q;
  logic [IDX_W-1:0]    rd_idx;
  logic [IDX_W-1:0]    dec_idx;
  logic                in_range;
  logic                match;

  logic                ram_we;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic [HANDLE_W-1:0] stored_handle;
  logic [CTX_W-1:0]    stored_ctx;

  logic                used_set;
  logic                used_clr;
  logic                gen_adv;
  ght_status_e         res_status;
  logic [HANDLE_W-1:0] res_handle;
  logic [SLOT_W-1:0]   res_slot;
  logic [CTX_W-1:0]    res_ctx;

  // lowest group with a free slot, registered at load
  always_comb begin
    used_pad = '1;
    used_pad[SLOTS-1:0] = used_q;
    grp_d = '0;
    for (int g = 0; g < NGRP; g++) begin
      grp_free[g] = ~&used_pad[g*GRP_W +: GRP_W];
    end
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_free[g]) begin
        grp_d = GIDX_W'(g);
      end
    end
  end

  // lowest free slot inside the chosen group
  always_comb begin
    grp_bits = used_pad[32'(grp_q) * GRP_W +: GRP_W];
    off = '0;
    for (int b = GRP_W - 1; b >= 0; b--) begin
      if (!grp_bits[b]) begin
        off = OFF_W'(b);
      end
    end
    alloc_idx = IDX_W'(32'(grp_q) * GRP_W + 32'(off));
  end

  always_comb begin
    gen_inc      = gen_q + GEN_W'(1);
    gen_next     = (gen_inc == GEN_LIMIT) ? GEN_FIRST : gen_inc;
    alloc_handle = {gen_next, LOW_W'(alloc_idx) + LOW_W'(1)};
  end

  // handle decode
  assign low_in   = handle_i[LOW_W-1:0];
  assign low_q    = handle_q[LOW_W-1:0];
  assign dec_in   = low_in - LOW_W'(1);
  assign dec_q    = low_q - LOW_W'(1);
  assign rd_idx   = cmd_i.load ? dec_in[IDX_W-1:0] : dec_q[IDX_W-1:0];
  assign dec_idx  = dec_q[IDX_W-1:0];
  assign in_range = (low_q != '0) && ({1'b0, low_q} <= SLOTS_L);

  assign stored_handle = ram_rdata[HANDLE_W-1:0];
  assign stored_ctx    = ram_rdata[ENTRY_W-1:HANDLE_W];
  assign match = used_q[dec_idx] && !handle_q[WORD_W-1]
                 && (stored_handle == handle_q[HANDLE_W-1:0]);

  // result and state updates of one committed word
  always_comb begin
    res_status = ST_RANGE;
    res_handle = '0;
    res_slot   = '0;
    res_ctx    = '0;
    used_set   = 1'b0;
    used_clr   = 1'b0;
    gen_adv    = 1'b0;
    case (op_q)
      OP_ALLOC: begin
        if (grp_found_q) begin
          res_status = ST_OK;
          res_handle = alloc_handle;
          res_slot   = SLOT_W'(alloc_idx);
          used_set   = 1'b1;
          gen_adv    = 1'b1;
        end else begin
          res_status = ST_FULL;
        end
      end
      OP_FREE, OP_LOOKUP: begin
        if (in_range) begin
          res_slot = dec_q[SLOT_W-1:0];
          if (!match) begin
            res_status = ST_MISMATCH;
          end else begin
            res_status = ST_OK;
            if (op_q == OP_FREE) begin
              used_clr = 1'b1;
            end else begin
              res_ctx = stored_ctx;
            end
          end
        end
      end
      default: begin
        res_status = ST_RANGE;
      end
    endcase
  end

  assign ram_we    = cmd_i.commit && used_set;
  assign ram_wdata = {ctx_q, alloc_handle};

  ght_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (alloc_idx),
    .wdata_i (ram_wdata),
    .raddr_i (rd_idx),
    .rdata_o (ram_rdata)
  );

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q        <= ght_op_e'(op_i);
      handle_q    <= handle_i;
      ctx_q       <= context_req_i;
      grp_q       <= grp_d;
      grp_found_q <= |grp_free;
    end
  end

  // table state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      gen_q  <= '0;
    end else if (cmd_i.commit) begin
      if (used_set) begin
        used_q[alloc_idx] <= 1'b1;
      end
      if (used_clr) begin
        used_q[dec_idx] <= 1'b0;
      end
      if (gen_adv) begin
        gen_q <= gen_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q     <= res_status;
      new_handle_q <= res_handle;
      slot_q       <= res_slot;
      ctx_out_q    <= res_ctx;
    end
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign new_handle_o   = new_handle_q;
  assign slot_o         = slot_q;
  assign context_out_o  = ctx_out_q;

endmodule
`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the generational handle table: a queue of requests
// (a short directed list, then phases of allocate, free and lookup words with
// shifting mix) feeds a bursty driver, a receiver stalls on its own pattern and
// at times holds off long, and every answer is compared against a local model of
// the slot table updated at each accepted request
// ----------------------------------------------------------------------------
module tb_top;
  import ght_pkg::*;

  localparam int SLOTS = SLOTS_DEF;
  localparam int PLAN = 0;
  localparam int TRACK = 1;
  localparam int RANDOM_WORDS = 950;

  typedef struct packed {
    ght_op_e     op;
    logic [31:0] handle;
    logic [31:0] ctx;
  } request_t;

  typedef struct packed {
    ght_status_e          status;
    logic [HANDLE_W-1:0]  new_handle;
    logic [SLOT_W-1:0]    slot;
    logic [CTX_W-1:0]     ctx;
  } answer_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [OP_W-1:0]      op_i = OP_ALLOC;
  logic [WORD_W-1:0]    handle_i = '0;
  logic [CTX_W-1:0]     context_req_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [STATUS_W-1:0]  status_o;
  logic [HANDLE_W-1:0]  new_handle_o;
  logic [SLOT_W-1:0]    slot_o;
  logic [CTX_W-1:0]     context_out_o;

  // two copies of the table: one steers stimulus, one checks answers
  logic                slot_live [2][SLOTS];
  logic                slot_seen [2][SLOTS];
  logic [HANDLE_W-1:0] slot_tag  [2][SLOTS];
  logic [CTX_W-1:0]    slot_word [2][SLOTS];
  logic [GEN_W-1:0]    gen_now   [2];

  request_t req_backlog[$];
  answer_t  answer_q[$];
  int       n_words = 0;
  int       n_taken = 0;
  int       n_answers = 0;
  int       errors = 0;
  logic     in_taken = 1'b0;
  int       burst_left = 0;
  int       gap_left = 0;
  int       rx_cyc = 0;
  int       rx_mode = 0;
  int       hold_left = 0;
  int       hold_mark = 200;

  generational_handle_table #(.SLOTS(SLOTS)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .handle_i      (handle_i),
    .context_req_i (context_req_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .new_handle_o  (new_handle_o),
    .slot_o        (slot_o),
    .context_out_o (context_out_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic answer_t table_answer(int m, request_t rq);
    answer_t          r;
    logic             found;
    int               s;
    logic [15:0]      low;
    logic [GEN_W-1:0] g;
    r = '0;
    r.status = ST_OK;
    found = 1'b0;
    s = 0;
    if (rq.op == OP_ALLOC) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!found && !slot_live[m][i]) begin
          found = 1'b1;
          s = i;
        end
      end
      if (!found) begin
        r.status = ST_FULL;
      end else begin
        g = gen_now[m] + 1'b1;
        if (g == GEN_LIMIT) begin
          g = GEN_FIRST;
        end
        gen_now[m] = g;
        r.new_handle = {g, 16'(s + 1)};
        r.slot = SLOT_W'(s);
        slot_live[m][s] = 1'b1;
        slot_seen[m][s] = 1'b1;
        slot_tag[m][s] = r.new_handle;
        slot_word[m][s] = rq.ctx;
      end
      return r;
    end
    low = rq.handle[15:0];
    if (rq.op == OP_RSVD || low == 16'd0 || low > SLOTS) begin
      r.status = ST_RANGE;
      return r;
    end
    s = int'(low) - 1;
    r.slot = SLOT_W'(s);
    if (!slot_live[m][s] || {1'b0, slot_tag[m][s]} != rq.handle) begin
      r.status = ST_MISMATCH;
    end else if (rq.op == OP_FREE) begin
      slot_live[m][s] = 1'b0;
      slot_tag[m][s] = '0;
    end else begin
      r.ctx = slot_word[m][s];
    end
    return r;
  endfunction

  task automatic plan_add(ght_op_e op, logic [31:0] handle, logic [31:0] ctx);
    request_t rq;
    answer_t  unused;
    rq.op = op;
    rq.handle = handle;
    rq.ctx = ctx;
    req_backlog.push_back(rq);
    unused = table_answer(PLAN, rq);
    n_words++;
  endtask

  // random slot that is live (or written and since freed)
  function automatic int pick_slot(logic want_live);
    int hits[$];
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_seen[PLAN][i] && slot_live[PLAN][i] == want_live) begin
        hits.push_back(i);
      end
    end
    if (hits.size() == 0) begin
      return -1;
    end
    return hits[$urandom_range(0, hits.size() - 1)];
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s expected %0h got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // stimulus plan and end of run
  initial begin
    int          alloc_pct;
    int          phase_len;
    int          s;
    int          pick;
    logic [31:0] h;
    logic [31:0] hr;
    ght_op_e     op;
    for (int m = 0; m < 2; m++) begin
      gen_now[m] = '0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_live[m][i] = 1'b0;
        slot_seen[m][i] = 1'b0;
        slot_tag[m][i] = '0;
        slot_word[m][i] = '0;
      end
    end

    plan_add(OP_LOOKUP, 32'h0000_0000, $urandom);
    plan_add(OP_FREE, 32'hFFFF_FFFF, 32'h0000_0000);
    plan_add(OP_LOOKUP, 32'(SLOTS + 1), 32'hFFFF_FFFF);
    plan_add(OP_RSVD, 32'h0000_0001, $urandom);
    plan_add(OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    plan_add(OP_ALLOC, 32'h0000_0000, 32'h0000_0000);
    plan_add(OP_ALLOC, $urandom, 32'hA5A5_5A5A);
    h = {1'b0, slot_tag[PLAN][0]};
    plan_add(OP_LOOKUP, h, $urandom);
    plan_add(OP_LOOKUP, h | 32'h8000_0000, $urandom);
    plan_add(OP_LOOKUP, h ^ 32'h0001_0000, $urandom);
    plan_add(OP_FREE, h ^ 32'h7FFF_0000, $urandom);
    plan_add(OP_FREE, h, $urandom);
    plan_add(OP_FREE, h, $urandom);
    plan_add(OP_LOOKUP, h, $urandom);
    plan_add(OP_ALLOC, $urandom, 32'h0000_0001);
    plan_add(OP_LOOKUP, {1'b0, slot_tag[PLAN][1]}, $urandom);
    plan_add(OP_LOOKUP, {1'b0, slot_tag[PLAN][0]}, $urandom);
    plan_add(OP_FREE, {1'b0, slot_tag[PLAN][2]}, $urandom);
    plan_add(OP_RSVD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // phases with a shifting share of allocates, so the table fills and drains
    while (n_words < RANDOM_WORDS) begin
      phase_len = $urandom_range(60, 140);
      if (phase_len > RANDOM_WORDS - n_words) begin
        phase_len = RANDOM_WORDS - n_words;
      end
      case ($urandom_range(0, 3))
        0: alloc_pct = 85;
        1: alloc_pct = 60;
        2: alloc_pct = 35;
        default: alloc_pct = 15;
      endcase
      repeat (phase_len) begin
        hr = $urandom;
        if ($urandom_range(0, 99) < alloc_pct) begin
          case ($urandom_range(0, 5))
            0: plan_add(OP_ALLOC, hr, 32'h0000_0000);
            1: plan_add(OP_ALLOC, hr, 32'hFFFF_FFFF);
            default: plan_add(OP_ALLOC, hr, $urandom);
          endcase
        end else begin
          op = $urandom_range(0, 1) ? OP_FREE : OP_LOOKUP;
          pick = $urandom_range(0, 9);
          s = pick_slot(1'b1);
          if (pick < 6 && s >= 0) begin
            plan_add(op, {1'b0, slot_tag[PLAN][s]}, $urandom);
          end else if (pick == 6 && s >= 0) begin
            h = {1'b0, slot_tag[PLAN][s]};
            h[30:16] = h[30:16] ^ 15'($urandom_range(1, 32767));
            h[31] = $urandom_range(0, 1);
            plan_add(op, h, $urandom);
          end else if (pick == 7 && s >= 0) begin
            plan_add(op, {1'b0, slot_tag[PLAN][s]} | 32'h8000_0000, $urandom);
          end else if (pick == 8) begin
            h = hr;
            h[15:0] = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(SLOTS + 1, 65535));
            plan_add($urandom_range(0, 3) == 0 ? OP_RSVD : op, h, $urandom);
          end else begin
            s = pick_slot(1'b0);
            if (s >= 0) begin
              plan_add(op, {hr[31:16], 16'(s + 1)}, $urandom);
            end else begin
              plan_add(OP_ALLOC, hr, $urandom);
            end
          end
        end
      end
    end

    wait (rst_ni);
    while (n_taken != n_words || answer_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (20) @(negedge clk_i);
    if (answer_q.size() != 0) begin
      $error("%0d answers never arrived", answer_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // driver: bursts of words with random gaps
  always @(negedge clk_i) begin
    request_t cur;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (gap_left != 0 || req_backlog.size() == 0) begin
        in_valid_i <= 1'b0;
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
        end
      end else begin
        cur = req_backlog.pop_front();
        in_valid_i <= 1'b1;
        op_i <= cur.op;
        handle_i <= cur.handle;
        context_req_i <= cur.ctx;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver: stall pattern picked at random from four modes, plus long hold-offs
  always @(negedge clk_i) begin
    rx_cyc <= rx_cyc + 1;
    if (rx_cyc % 50 == 0) begin
      rx_mode <= $urandom_range(0, 3);
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (n_answers >= hold_mark) begin
      out_stall_i <= 1'b1;
      hold_left <= 300;
      hold_mark <= hold_mark + 400;
    end else begin
      case (rx_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 2) == 0);
        2: out_stall_i <= rx_cyc[0];
        default: out_stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // monitor: predict on each accepted request, check each accepted answer
  always @(posedge clk_i) begin
    request_t rq;
    answer_t  exp_a;
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        rq.op = ght_op_e'(op_i);
        rq.handle = handle_i;
        rq.ctx = context_req_i;
        answer_q.push_back(table_answer(TRACK, rq));
        n_taken <= n_taken + 1;
      end
      if (out_valid_o && !out_stall_i) begin
        n_answers <= n_answers + 1;
        if (answer_q.size() == 0) begin
          $error("answer word with nothing expected: status %0h", status_o);
          errors++;
        end else begin
          exp_a = answer_q.pop_front();
          check_field("status", 32'(exp_a.status), 32'(status_o));
          check_field("new_handle", 32'(exp_a.new_handle), 32'(new_handle_o));
          check_field("slot", 32'(exp_a.slot), 32'(slot_o));
          check_field("context_out", exp_a.ctx, context_out_o);
        end
      end
    end
  end

endmodule

>>> filelist.f
src/ght_pkg.sv
src/ght_ram.sv
src/ght_ctrl.sv
src/ght_dp.sv
src/generational_handle_table.sv
dv/tb_top.sv
